// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);
// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/mqtt_pkg.sv -----
// ----------------------------------------------------------------------------
// mqtt_pkg
// Shared widths, event codes and defaults of the MQTT packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mqtt_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int EVT_W   = 3;
    localparam int PID_W   = 16;
    localparam int QOS_W   = 2;
    localparam int PLEN_W  = 28;

    // Defaults
    localparam int                 MAX_LEN_BYTES_DEF = 4;
    localparam logic [BYTE_W-1:0]  MAX_TOPIC_RST     = 8'd10;

    // Result event codes
    typedef enum logic [EVT_W-1:0] {
        EV_CONNACK = 3'd0,
        EV_PUBACK  = 3'd1,
        EV_SUBACK  = 3'd2,
        EV_PUB_HDR = 3'd3,
        EV_TOPIC   = 3'd4,
        EV_PAYLOAD = 3'd5,
        EV_DROP    = 3'd6
    } t_event;

    // Control packet types from fixed header bits 7:4
    localparam logic [3:0] KIND_CONNACK = 4'd2;
    localparam logic [3:0] KIND_PUBLISH = 4'd3;
    localparam logic [3:0] KIND_PUBACK  = 4'd4;
    localparam logic [3:0] KIND_SUBACK  = 4'd9;

endpackage

`default_nettype wire

// ----- sv/mqtt_if.sv -----
// ----------------------------------------------------------------------------
// mqtt_if
// Valid/ready channels of the parser: received bytes, results, config.
// ----------------------------------------------------------------------------
`default_nettype none

// Received byte channel
interface mqtt_in_if
    import mqtt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

// Result event channel
interface mqtt_out_if
    import mqtt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [EVT_W-1:0]  event_res;
    logic [PID_W-1:0]  packet_id;
    logic [BYTE_W-1:0] return_code;
    logic [QOS_W-1:0]  qos_level;
    logic [BYTE_W-1:0] topic_length;
    logic [PLEN_W-1:0] payload_length;
    logic [BYTE_W-1:0] byte_value;
    logic              last_of_run;

    modport source (output valid, output event_res, output packet_id, output return_code,
                    output qos_level, output topic_length, output payload_length,
                    output byte_value, output last_of_run, input ready);
    modport sink   (input valid, input event_res, input packet_id, input return_code,
                    input qos_level, input topic_length, input payload_length,
                    input byte_value, input last_of_run, output ready);
endinterface

// Configuration write channel
interface mqtt_cfg_if
    import mqtt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] max_topic_len;

    modport source (output valid, output max_topic_len, input ready);
    modport sink   (input valid, input max_topic_len, output ready);
endinterface

`default_nettype wire

// ----- sv/mqtt_packet_parser_core.sv -----
// ----------------------------------------------------------------------------
// mqtt_packet_parser_core
// MQTT 3.1.1 control packet parser, one received byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries the received bytes of one packet; frame_end marks the last
//   byte of a frame and returns the parser to idle after that byte.
//   o_res carries at most one event per byte: CONNACK code, PUBACK id,
//   SUBACK id and code, PUBLISH topic bytes, header and payload bytes, or a
//   drop notice for an overlong length or topic.
//   i_cfg writes max_topic_len; write it only while no byte is in flight.
//   Path: a byte's transfer loads the input register; the parse step
//   then computes its event, which the result register takes and
//   drives on o_res.
//   Throughput: one byte per cycle while o_res does not stall; the parse
//   state update is a single pass of logic between the input register
//   and the result register. When o_res stalls, the input register holds
//   its byte and i_in.ready drops only while both registers are full.
//   Reset: synchronous, active low; parser idle, max_topic_len = 10,
//   no event pending.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mqtt_packet_parser_core
    import mqtt_pkg::*;
#(
    parameter int MAX_LEN_BYTES = MAX_LEN_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mqtt_in_if.sink     i_in,
    mqtt_cfg_if.sink    i_cfg,
    mqtt_out_if.source  o_res
);

    // Parse phases
    typedef enum logic [11:0] {
        PH_IDLE    = 12'b0000_0000_0001,
        PH_LEN     = 12'b0000_0000_0010,
        PH_CFLAGS  = 12'b0000_0000_0100,
        PH_CCODE   = 12'b0000_0000_1000,
        PH_ID_HI   = 12'b0000_0001_0000,
        PH_ID_LO   = 12'b0000_0010_0000,
        PH_SCODE   = 12'b0000_0100_0000,
        PH_TLEN_HI = 12'b0000_1000_0000,
        PH_TLEN_LO = 12'b0001_0000_0000,
        PH_TOPIC   = 12'b0010_0000_0000,
        PH_PAYLOAD = 12'b0100_0000_0000,
        PH_SKIP    = 12'b1000_0000_0000
    } t_phase;

    // Config register
    logic [BYTE_W-1:0] r_max_topic;

    // Input register
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_fend;

    // Parse state
    t_phase            r_phase,     n_phase;
    logic [3:0]        r_kind,      n_kind;
    logic [QOS_W-1:0]  r_qos,       n_qos;
    logic [PLEN_W-1:0] r_rem,       n_rem;
    logic [2:0]        r_vcount,    n_vcount;
    logic [PLEN_W-1:0] r_left,      n_left;
    logic [PID_W-1:0]  r_tlen,      n_tlen;
    logic [PID_W-1:0]  r_pid,       n_pid;
    logic [2:0]        r_frame_cnt, n_frame_cnt;

    // Result register
    logic              r_out_valid;
    logic [EVT_W-1:0]  r_evt,  n_evt;
    logic [PID_W-1:0]  r_opid, n_opid;
    logic [BYTE_W-1:0] r_code, n_code;
    logic [QOS_W-1:0]  r_oqos, n_oqos;
    logic [BYTE_W-1:0] r_otlen, n_otlen;
    logic [PLEN_W-1:0] r_oplen, n_oplen;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic              r_olast, n_olast;
    logic              n_emit;

    logic              out_free;
    logic              s1_fire;
    logic              in_fire;

    // Working values
    logic [PID_W-1:0]  w_tlen_cur;
    logic [PID_W-1:0]  w_pid_cur;
    logic [16:0]       w_used;
    logic [PLEN_W:0]   w_diff;
    logic [PLEN_W-1:0] w_psize;
    logic [PLEN_W-1:0] w_vadd;
    logic [PLEN_W-1:0] w_left_dec;
    logic [PID_W-1:0]  w_hdr_pid;

    // Handshakes
    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_fire     = r_s1_valid && out_free;
    assign i_in.ready  = !r_s1_valid || out_free;
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_topic <= MAX_TOPIC_RST;
        end else if (i_cfg.valid) begin
            r_max_topic <= i_cfg.max_topic_len;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_fend <= i_in.frame_end;
        end
    end

    // Topic length and packet id as seen by this byte
    assign w_tlen_cur = (r_phase == PH_TLEN_LO) ? {r_tlen[15:8], r_s1_byte} : r_tlen;
    assign w_pid_cur  = {r_pid[15:8], r_s1_byte};
    assign w_hdr_pid  = (r_qos != '0) ? w_pid_cur : '0;

    // Payload size: remaining length minus the variable header, floored at 0
    assign w_used  = 17'd2 + {1'b0, w_tlen_cur} + ((r_qos != '0) ? 17'd2 : 17'd0);
    assign w_diff  = {1'b0, r_rem} - {{(PLEN_W-16){1'b0}}, w_used};
    assign w_psize = w_diff[PLEN_W] ? '0 : w_diff[PLEN_W-1:0];

    assign w_left_dec = r_left - 1'b1;

    // Length byte contribution by position
    always_comb begin
        case (r_vcount[1:0])
            2'd0:    w_vadd = {21'b0, r_s1_byte[6:0]};
            2'd1:    w_vadd = {14'b0, r_s1_byte[6:0], 7'b0};
            2'd2:    w_vadd = {7'b0, r_s1_byte[6:0], 14'b0};
            default: w_vadd = {r_s1_byte[6:0], 21'b0};
        endcase
    end

    // Parse step
    always_comb begin
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_qos       = r_qos;
        n_rem       = r_rem;
        n_vcount    = r_vcount;
        n_left      = r_left;
        n_tlen      = r_tlen;
        n_pid       = r_pid;
        n_frame_cnt = r_frame_cnt;
        n_emit      = 1'b0;
        n_evt       = EV_CONNACK;
        n_opid      = '0;
        n_code      = '0;
        n_oqos      = '0;
        n_otlen     = '0;
        n_oplen     = '0;
        n_obyte     = '0;
        n_olast     = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                n_kind   = r_s1_byte[7:4];
                n_qos    = r_s1_byte[2:1];
                n_rem    = '0;
                n_vcount = '0;
                n_left   = '0;
                n_tlen   = '0;
                n_pid    = '0;
                n_phase  = PH_LEN;
            end
            PH_LEN: begin
                n_rem    = r_rem + w_vadd;
                n_vcount = r_vcount + 3'd1;
                if (r_s1_byte[7]) begin
                    if (n_vcount >= 3'(MAX_LEN_BYTES)) begin
                        n_evt   = EV_DROP;
                        n_emit  = 1'b1;
                        n_phase = PH_SKIP;
                    end
                end else begin
                    unique case (r_kind) inside
                        KIND_CONNACK:              n_phase = PH_CFLAGS;
                        KIND_PUBACK, KIND_SUBACK:  n_phase = PH_ID_HI;
                        KIND_PUBLISH:              n_phase = PH_TLEN_HI;
                        default:                   n_phase = PH_SKIP;
                    endcase
                end
            end
            PH_CFLAGS: begin
                n_phase = PH_CCODE;
            end
            PH_CCODE: begin
                n_evt   = EV_CONNACK;
                n_code  = r_s1_byte;
                n_emit  = 1'b1;
                n_phase = PH_SKIP;
            end
            PH_ID_HI: begin
                n_pid   = {r_s1_byte, 8'b0};
                n_phase = PH_ID_LO;
            end
            PH_ID_LO: begin
                n_pid = w_pid_cur;
                if (r_kind == KIND_PUBACK) begin
                    n_evt   = EV_PUBACK;
                    n_opid  = w_pid_cur;
                    n_emit  = 1'b1;
                    n_phase = PH_SKIP;
                end else if (r_kind == KIND_SUBACK) begin
                    n_phase = PH_SCODE;
                end else begin
                    // publish header after the packet id
                    n_evt   = EV_PUB_HDR;
                    n_opid  = w_hdr_pid;
                    n_oqos  = r_qos;
                    n_otlen = w_tlen_cur[7:0];
                    n_oplen = w_psize;
                    n_emit  = 1'b1;
                    n_left  = w_psize;
                    n_phase = (w_psize != '0) ? PH_PAYLOAD : PH_SKIP;
                end
            end
            PH_SCODE: begin
                n_evt   = EV_SUBACK;
                n_opid  = r_pid;
                n_code  = r_s1_byte;
                n_emit  = 1'b1;
                n_phase = PH_SKIP;
            end
            PH_TLEN_HI: begin
                n_tlen  = {r_s1_byte, 8'b0};
                n_phase = PH_TLEN_LO;
            end
            PH_TLEN_LO: begin
                n_tlen = w_tlen_cur;
                if (w_tlen_cur > {8'b0, r_max_topic}) begin
                    n_evt   = EV_DROP;
                    n_emit  = 1'b1;
                    n_phase = PH_SKIP;
                end else begin
                    // QoS 0 has no id, so the header goes out before the topic
                    if (r_qos == '0) begin
                        n_evt   = EV_PUB_HDR;
                        n_otlen = w_tlen_cur[7:0];
                        n_oplen = w_psize;
                        n_emit  = 1'b1;
                    end
                    if (w_tlen_cur != '0) begin
                        n_left  = {{(PLEN_W-PID_W){1'b0}}, w_tlen_cur};
                        n_phase = PH_TOPIC;
                    end else if (r_qos != '0) begin
                        n_phase = PH_ID_HI;
                    end else begin
                        n_left  = w_psize;
                        n_phase = (w_psize != '0) ? PH_PAYLOAD : PH_SKIP;
                    end
                end
            end
            PH_TOPIC: begin
                n_left  = w_left_dec;
                n_evt   = EV_TOPIC;
                n_obyte = r_s1_byte;
                n_olast = (w_left_dec == '0);
                n_emit  = 1'b1;
                if (w_left_dec == '0) begin
                    if (r_qos != '0) begin
                        n_phase = PH_ID_HI;
                    end else begin
                        n_left  = w_psize;
                        n_phase = (w_psize != '0) ? PH_PAYLOAD : PH_SKIP;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_left  = w_left_dec;
                n_evt   = EV_PAYLOAD;
                n_obyte = r_s1_byte;
                n_olast = (w_left_dec == '0);
                n_emit  = 1'b1;
                if (w_left_dec == '0) begin
                    n_phase = PH_SKIP;
                end
            end
            default: begin
                n_phase = PH_SKIP;
            end
        endcase

        // nothing is reported before the fourth byte of a frame
        if (r_frame_cnt < 3'd3) begin
            n_emit = 1'b0;
        end
        if (r_frame_cnt < 3'd4) begin
            n_frame_cnt = r_frame_cnt + 3'd1;
        end

        if (r_s1_fend) begin
            n_phase     = PH_IDLE;
            n_frame_cnt = '0;
        end
    end

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_kind      <= '0;
            r_qos       <= '0;
            r_rem       <= '0;
            r_vcount    <= '0;
            r_left      <= '0;
            r_tlen      <= '0;
            r_pid       <= '0;
            r_frame_cnt <= '0;
        end else if (s1_fire) begin
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_qos       <= n_qos;
            r_rem       <= n_rem;
            r_vcount    <= n_vcount;
            r_left      <= n_left;
            r_tlen      <= n_tlen;
            r_pid       <= n_pid;
            r_frame_cnt <= n_frame_cnt;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_fire && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && n_emit) begin
            r_evt   <= n_evt;
            r_opid  <= n_opid;
            r_code  <= n_code;
            r_oqos  <= n_oqos;
            r_otlen <= n_otlen;
            r_oplen <= n_oplen;
            r_obyte <= n_obyte;
            r_olast <= n_olast;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.event_res      = r_evt;
    assign o_res.packet_id      = r_opid;
    assign o_res.return_code    = r_code;
    assign o_res.qos_level      = r_oqos;
    assign o_res.topic_length   = r_otlen;
    assign o_res.payload_length = r_oplen;
    assign o_res.byte_value     = r_obyte;
    assign o_res.last_of_run    = r_olast;

    // Checks
    `ASSERT_RST(a_frame_cnt_sat, i_clk, i_rst_n, r_frame_cnt <= 3'd4, "frame count overrun")
    `ASSERT_IMPL(a_fend_to_idle, i_clk, i_rst_n, s1_fire && r_s1_fend, ##1 (r_phase == PH_IDLE && r_frame_cnt == '0), "frame end did not return to idle")
    `ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, !i_in.ready, r_s1_valid && r_out_valid && !o_res.ready, "input stalled without a full pipeline")
    `ASSERT_IMPL(a_last_kind, i_clk, i_rst_n, r_out_valid && r_olast, r_evt == EV_TOPIC || r_evt == EV_PAYLOAD, "last mark on a non-stream event")

endmodule

`default_nettype wire
